[design/sktab_pkg.sv]
// Shared types, codes and constants of the sorted key table engine.
`default_nettype none
package sktab_pkg;
	localparam int DefCapacity = 128;
	localparam int KeyW = 64;

	typedef enum logic [3:0] {
		OP_INS_HEAD = 4'd0,
		OP_INS_AT   = 4'd1,
		OP_INS_END  = 4'd2,
		OP_RM_NAME  = 4'd3,
		OP_RM_PHONE = 4'd4,
		OP_RM_POS   = 4'd5,
		OP_SORT     = 4'd6,
		OP_SEQ_FIND = 4'd7,
		OP_BIN_FIND = 4'd8
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_DUP      = 3'd2,
		ST_BADPOS   = 3'd3,
		ST_EMPTY    = 3'd4,
		ST_NOTFOUND = 3'd5,
		ST_BADOP    = 3'd6
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DUP_RD,
		S_DUP_CHK,
		S_INS_RD,
		S_INS_WR,
		S_FIND_RD,
		S_FIND_CHK,
		S_RM_RD,
		S_RM_WR,
		S_SORT_LD,
		S_SORT_RD,
		S_SORT_CHK,
		S_SORT_WB,
		S_BIN_RD,
		S_BIN_CHK,
		S_DONE
	} state_t;
endpackage
`default_nettype wire

[design/sktab_ram.sv]
// Generic single-port synchronous RAM with registered read.
`default_nettype none
module sktab_ram #(
	parameter int Width = 64,
	parameter int Depth = 128
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(Depth)-1:0]  addr,
	input  wire [Width-1:0]          wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	// write or read one word per cycle
	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

[design/sorted_key_table_engine_top.sv]
// Top level of the sorted key table engine: sequencer around two entry RAMs.
// One item is worked at a time through single-port name and phone RAMs, one
// entry access per cycle. Inserts scan for duplicates, reading then checking
// each entry, then shift the tail up, reading then writing each moved entry;
// removals search then shift down; sort is a bubble sort of compare steps
// and an end-of-pass write-back, with passes until clean; finds sort first,
// then a sequential find checks each entry and a binary find each probe.
// The input stall is high from acceptance until the result word is taken.
// No clearing pass is needed after reset.
`default_nettype none
module sorted_key_table_engine_top import sktab_pkg::*; #(
	parameter int Capacity = DefCapacity
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [3:0]  opcode,
	input  wire  [63:0] name_key,
	input  wire  [63:0] phone_key,
	input  wire  [7:0]  position,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [2:0]  status,
	output logic [6:0]  found_position,
	output logic [63:0] found_name,
	output logic [63:0] found_phone,
	output logic [7:0]  used_count,
	output logic [7:0]  free_count
);
	localparam int AW = $clog2(Capacity);
	localparam int CW = $clog2(Capacity + 1);

	state_t state_q, state_d;
	logic [3:0] op_q;
	logic [KeyW-1:0] nm_q, ph_q, hold_nm_q, hold_ph_q;
	logic [CW-1:0] cnt_q, slot_q, idx_q, lo_q, hi_q;
	logic swapped_q;
	logic [2:0] st_q;

	logic we;
	logic [AW-1:0] addr;
	logic [KeyW-1:0] wn, wp, rn, rp;

	sktab_ram #(.Width(KeyW), .Depth(Capacity)) u_name (
		.clk(clk), .we(we), .addr(addr), .wdata(wn), .rdata(rn));
	sktab_ram #(.Width(KeyW), .Depth(Capacity)) u_phone (
		.clk(clk), .we(we), .addr(addr), .wdata(wp), .rdata(rp));

	logic [CW-1:0] mid;
	assign mid = lo_q + ((hi_q - lo_q) >> 1);

	// next-state values and result registers for the sequencer
	logic [CW-1:0] cnt_d, slot_d, idx_d, lo_d, hi_d;
	logic swapped_d;
	logic [2:0] st_d;
	logic [KeyW-1:0] hold_nm_d, hold_ph_d;
	logic [KeyW-1:0] fn_d, fp_d;
	logic [KeyW-1:0] fn_q, fp_q;
	logic [CW-1:0] fpos_d, fpos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			op_q <= opcode;
			nm_q <= name_key;
			ph_q <= phone_key;
		end
		slot_q <= slot_d;
		idx_q <= idx_d;
		lo_q <= lo_d;
		hi_q <= hi_d;
		swapped_q <= swapped_d;
		st_q <= st_d;
		hold_nm_q <= hold_nm_d;
		hold_ph_q <= hold_ph_d;
		fn_q <= fn_d;
		fp_q <= fp_d;
		fpos_q <= fpos_d;
	end

	// sequence one item through the RAMs
	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		slot_d = slot_q;
		idx_d = idx_q;
		lo_d = lo_q;
		hi_d = hi_q;
		swapped_d = swapped_q;
		st_d = st_q;
		hold_nm_d = hold_nm_q;
		hold_ph_d = hold_ph_q;
		fn_d = fn_q;
		fp_d = fp_q;
		fpos_d = fpos_q;
		we = 1'b0;
		addr = idx_q[AW-1:0];
		wn = hold_nm_q;
		wp = hold_ph_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					st_d = ST_OK;
					fn_d = '0;
					fp_d = '0;
					fpos_d = '0;
					idx_d = '0;
					swapped_d = 1'b0;
					state_d = S_DONE;
					case (opcode)
						OP_INS_HEAD, OP_INS_AT, OP_INS_END: begin
							if (opcode == OP_INS_HEAD)
								slot_d = '0;
							else if (opcode == OP_INS_END)
								slot_d = cnt_q;
							else
								slot_d = CW'(position);
							if (cnt_q >= CW'(Capacity))
								st_d = ST_FULL;
							else if (opcode == OP_INS_AT &&
									{1'b0, position} > 9'(cnt_q))
								st_d = ST_BADPOS;
							else if (cnt_q == '0)
								state_d = S_INS_WR;
							else
								state_d = S_DUP_RD;
							idx_d = '0;
						end
						OP_RM_NAME, OP_RM_PHONE, OP_RM_POS: begin
							if (cnt_q == '0)
								st_d = ST_EMPTY;
							else if (opcode == OP_RM_POS) begin
								if ({1'b0, position} >= 9'(cnt_q))
									st_d = ST_BADPOS;
								else begin
									idx_d = CW'(position);
									slot_d = CW'(position);
									state_d = S_FIND_RD;
								end
							end else
								state_d = S_FIND_RD;
						end
						OP_SORT, OP_SEQ_FIND, OP_BIN_FIND: begin
							if (opcode != OP_SORT && cnt_q == '0)
								st_d = ST_EMPTY;
							else if (cnt_q >= CW'(2))
								state_d = S_SORT_LD;
							else if (opcode == OP_SORT)
								state_d = S_DONE;
							else if (opcode == OP_SEQ_FIND)
								state_d = S_FIND_RD;
							else begin
								lo_d = '0;
								hi_d = cnt_q;
								state_d = S_BIN_RD;
							end
						end
						default: st_d = ST_BADOP;
					endcase
				end
			end
			// duplicate scan: read entry, compare next cycle
			S_DUP_RD: state_d = S_DUP_CHK;
			S_DUP_CHK: begin
				if (rn == nm_q || rp == ph_q) begin
					st_d = ST_DUP;
					state_d = S_DONE;
				end else if (idx_q + 1'b1 >= cnt_q) begin
					idx_d = cnt_q;
					state_d = (cnt_q == slot_q) ? S_INS_WR : S_INS_RD;
				end else begin
					idx_d = idx_q + 1'b1;
					state_d = S_DUP_RD;
				end
			end
			// insert shift: read idx-1, write it at idx
			S_INS_RD: begin
				addr = AW'(idx_q - 1'b1);
				state_d = S_INS_WR;
			end
			S_INS_WR: begin
				we = 1'b1;
				if (idx_q == slot_q) begin
					wn = nm_q;
					wp = ph_q;
					fn_d = nm_q;
					fp_d = ph_q;
					fpos_d = slot_q;
					cnt_d = cnt_q + 1'b1;
					state_d = S_DONE;
				end else begin
					wn = rn;
					wp = rp;
					idx_d = idx_q - 1'b1;
					state_d = (idx_q - 1'b1 == slot_q) ? S_INS_WR : S_INS_RD;
				end
			end
			// linear find for remove and sequential find
			S_FIND_RD: state_d = S_FIND_CHK;
			S_FIND_CHK: begin
				if (op_q == OP_RM_POS || (op_q == OP_RM_PHONE && rp == ph_q) ||
						(op_q != OP_RM_PHONE && rn == nm_q)) begin
					fn_d = rn;
					fp_d = rp;
					fpos_d = idx_q;
					slot_d = idx_q;
					if (op_q == OP_SEQ_FIND)
						state_d = S_DONE;
					else if (idx_q + 1'b1 >= cnt_q) begin
						cnt_d = cnt_q - 1'b1;
						state_d = S_DONE;
					end else begin
						idx_d = idx_q + 1'b1;
						state_d = S_RM_RD;
					end
				end else if (idx_q + 1'b1 >= cnt_q) begin
					st_d = ST_NOTFOUND;
					state_d = S_DONE;
				end else begin
					idx_d = idx_q + 1'b1;
					state_d = S_FIND_RD;
				end
			end
			// remove shift: read idx, write it at idx-1
			S_RM_RD: state_d = S_RM_WR;
			S_RM_WR: begin
				we = 1'b1;
				addr = AW'(idx_q - 1'b1);
				wn = rn;
				wp = rp;
				if (idx_q + 1'b1 >= cnt_q) begin
					cnt_d = cnt_q - 1'b1;
					state_d = S_DONE;
				end else begin
					idx_d = idx_q + 1'b1;
					state_d = S_RM_RD;
				end
			end
			// bubble pass: read entry 0 to start the carried entry
			S_SORT_LD: state_d = S_SORT_RD;
			// load the carried entry at pass start, read entry idx+1
			S_SORT_RD: begin
				if (idx_q == '0) begin
					hold_nm_d = rn;
					hold_ph_d = rp;
				end
				addr = AW'(idx_q + 1'b1);
				state_d = S_SORT_CHK;
			end
			// write the smaller entry at idx, carry the larger one
			S_SORT_CHK: begin
				we = 1'b1;
				if (rn < hold_nm_q) begin
					wn = rn;
					wp = rp;
					swapped_d = 1'b1;
				end else begin
					hold_nm_d = rn;
					hold_ph_d = rp;
				end
				idx_d = idx_q + 1'b1;
				state_d = (idx_q + CW'(2) >= cnt_q) ? S_SORT_WB : S_SORT_RD;
			end
			// write the carried entry at the last slot, then repeat or go on
			S_SORT_WB: begin
				we = 1'b1;
				if (swapped_q) begin
					idx_d = '0;
					swapped_d = 1'b0;
					state_d = S_SORT_LD;
				end else if (op_q == OP_SEQ_FIND) begin
					idx_d = '0;
					state_d = S_FIND_RD;
				end else if (op_q == OP_BIN_FIND) begin
					lo_d = '0;
					hi_d = cnt_q;
					state_d = S_BIN_RD;
				end else
					state_d = S_DONE;
			end
			S_BIN_RD: begin
				addr = mid[AW-1:0];
				state_d = S_BIN_CHK;
			end
			S_BIN_CHK: begin
				if (rn == nm_q) begin
					fn_d = rn;
					fp_d = rp;
					fpos_d = mid;
					state_d = S_DONE;
				end else begin
					if (rn < nm_q)
						lo_d = mid + 1'b1;
					else
						hi_d = mid;
					if ((rn < nm_q ? mid + 1'b1 : lo_q) >= (rn < nm_q ? hi_q : mid)) begin
						st_d = ST_NOTFOUND;
						state_d = S_DONE;
					end else
						state_d = S_BIN_RD;
				end
			end
			S_DONE: begin
				if (!out_stall)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_DONE);
	assign status = st_q;
	assign found_position = 7'(fpos_q);
	assign found_name = fn_q;
	assign found_phone = fp_q;
	assign used_count = 8'(cnt_q);
	assign free_count = 8'(CW'(Capacity) - cnt_q);
endmodule
`default_nettype wire

[design/sktab_checker.sv]
// Port-level checks of the sorted key table engine, bound to its top level.
`default_nettype none
module sktab_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       in_stall,
	input wire       out_valid,
	input wire       out_stall,
	input wire [2:0] status,
	input wire [7:0] used_count,
	input wire [7:0] free_count
);
	// a result stays offered until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result dropped");
	// no new word is taken while a result waits
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken during result");
	// counts add to 128, the default capacity, whenever a result is offered
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (9'(used_count) + 9'(free_count) == 9'd128))
		else $error("count mismatch");
	// counts change only across an item
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && !in_stall |=> $stable(used_count) || in_stall)
		else $error("count moved while idle");
	// status carries a defined code
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= 3'd6) else $error("status code undefined");
endmodule

bind sorted_key_table_engine_top sktab_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .status(status),
	.used_count(used_count), .free_count(free_count));
`default_nettype wire

[sim/sorted_key_table_engine_top_tb.sv]
// Self-checking testbench of the sorted key table engine: contact table predictor and drivers.
`default_nettype none
module sorted_key_table_engine_top_tb;
	import sktab_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int Capacity = DefCapacity;
	localparam int SmallTable = 24;
	localparam int RandomItems = 820;
	localparam int QuietTail = 150;
	localparam logic [3:0] OpUnusedLo = 4'(OP_BIN_FIND) + 4'd1;
	localparam logic [3:0] OpUnusedHi = 4'hF;

	typedef struct {
		logic [2:0]  status;
		logic [6:0]  slot;
		logic [63:0] name;
		logic [63:0] phone;
		logic [7:0]  used;
		logic [7:0]  free;
	} reply_t;

	// Contact table predictor and queue of replies still owed by the block
	class contact_table_model;
		logic [63:0] names[Capacity];
		logic [63:0] phones[Capacity];
		int count;
		int errors;
		int checked;
		reply_t owed[$];

		function new();
			count = 0;
			errors = 0;
			checked = 0;
		endfunction

		// stable bubble sort by name
		function void order_by_name();
			bit swapped;
			logic [63:0] tn, tp;
			if (count < 2)
				return;
			do begin
				swapped = 0;
				for (int i = 0; i + 1 < count; i++) begin
					if (names[i] > names[i + 1]) begin
						tn = names[i];
						tp = phones[i];
						names[i] = names[i + 1];
						phones[i] = phones[i + 1];
						names[i + 1] = tn;
						phones[i + 1] = tp;
						swapped = 1;
					end
				end
			end while (swapped);
		endfunction

		// work out the reply of one accepted request word
		function void note_request(logic [3:0] op, logic [63:0] nm, logic [63:0] ph,
				logic [7:0] pos);
			reply_t r;
			status_t st;
			int slot, lo, hi, mid;
			bit hit, taken;
			st = ST_OK;
			slot = 0;
			hit = 0;
			case (op)
				OP_INS_HEAD, OP_INS_AT, OP_INS_END: begin
					slot = (op == OP_INS_HEAD) ? 0 : (op == OP_INS_END) ? count : int'(pos);
					taken = 0;
					for (int i = 0; i < count; i++)
						if (names[i] == nm || phones[i] == ph)
							taken = 1;
					if (count >= Capacity)
						st = ST_FULL;
					else if (slot > count)
						st = ST_BADPOS;
					else if (taken)
						st = ST_DUP;
					else begin
						for (int i = count; i > slot; i--) begin
							names[i] = names[i - 1];
							phones[i] = phones[i - 1];
						end
						names[slot] = nm;
						phones[slot] = ph;
						count++;
						hit = 1;
					end
				end
				OP_RM_NAME, OP_RM_PHONE, OP_RM_POS: begin
					if (count == 0)
						st = ST_EMPTY;
					else if (op == OP_RM_POS) begin
						if (pos >= count)
							st = ST_BADPOS;
						else begin
							slot = pos;
							hit = 1;
						end
					end else begin
						for (int i = 0; i < count && !hit; i++)
							if ((op == OP_RM_NAME && names[i] == nm) ||
									(op == OP_RM_PHONE && phones[i] == ph)) begin
								slot = i;
								hit = 1;
							end
						if (!hit)
							st = ST_NOTFOUND;
					end
				end
				OP_SORT: order_by_name();
				OP_SEQ_FIND, OP_BIN_FIND: begin
					if (count == 0)
						st = ST_EMPTY;
					else begin
						order_by_name();
						if (op == OP_SEQ_FIND) begin
							for (int i = 0; i < count && !hit; i++)
								if (names[i] == nm) begin
									slot = i;
									hit = 1;
								end
						end else begin
							lo = 0;
							hi = count;
							while (lo < hi && !hit) begin
								mid = lo + (hi - lo) / 2;
								if (names[mid] == nm) begin
									slot = mid;
									hit = 1;
								end else if (names[mid] < nm)
									lo = mid + 1;
								else
									hi = mid;
							end
						end
						if (!hit)
							st = ST_NOTFOUND;
					end
				end
				default: st = ST_BADOP;
			endcase
			r.name = '0;
			r.phone = '0;
			if (hit) begin
				r.name = names[slot];
				r.phone = phones[slot];
				// close the gap on removal
				if (op == OP_RM_NAME || op == OP_RM_PHONE || op == OP_RM_POS) begin
					for (int i = slot; i + 1 < count; i++) begin
						names[i] = names[i + 1];
						phones[i] = phones[i + 1];
					end
					count--;
				end
			end else
				slot = 0;
			r.status = st;
			r.slot = 7'(slot);
			r.used = 8'(count);
			r.free = 8'(Capacity - count);
			owed.push_back(r);
		endfunction

		// compare one reply word with the oldest one owed
		function void check_reply(reply_t got);
			reply_t e;
			if (owed.size() == 0) begin
				$error("unexpected reply word, status %0d", got.status);
				errors++;
				return;
			end
			e = owed.pop_front();
			checked++;
			if (got.status !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, got.status);
				errors++;
			end
			if (got.slot !== e.slot) begin
				$error("found_position: expected %0d, got %0d", e.slot, got.slot);
				errors++;
			end
			if (got.name !== e.name) begin
				$error("found_name: expected %h, got %h", e.name, got.name);
				errors++;
			end
			if (got.phone !== e.phone) begin
				$error("found_phone: expected %h, got %h", e.phone, got.phone);
				errors++;
			end
			if (got.used !== e.used) begin
				$error("used_count: expected %0d, got %0d", e.used, got.used);
				errors++;
			end
			if (got.free !== e.free) begin
				$error("free_count: expected %0d, got %0d", e.free, got.free);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [3:0]  opcode = '0;
	logic [63:0] name_key = '0;
	logic [63:0] phone_key = '0;
	logic [7:0]  position = '0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [2:0]  status;
	logic [6:0]  found_position;
	logic [63:0] found_name;
	logic [63:0] found_phone;
	logic [7:0]  used_count;
	logic [7:0]  free_count;

	contact_table_model table_model = new();
	logic [63:0] name_pool[16];
	logic [63:0] phone_pool[16];
	bit quiet = 0;
	int words_sent = 0;

	sorted_key_table_engine_top #(.Capacity(Capacity)) u_top (
		.clk, .arst_n, .in_valid, .in_stall, .opcode, .name_key, .phone_key, .position,
		.out_valid, .out_stall, .status, .found_position, .found_name, .found_phone,
		.used_count, .free_count
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#200_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// check every reply word taken from the block
	always @(posedge clk) begin
		reply_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.status = status;
			got.slot = found_position;
			got.name = found_name;
			got.phone = found_phone;
			got.used = used_count;
			got.free = free_count;
			table_model.check_reply(got);
		end
	end

	// stall the reply side in random bursts, none in the quiet tail
	initial begin
		forever begin
			if (!quiet && $urandom_range(0, 2) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	// present one request word and hold it until taken
	task automatic send_request(logic [3:0] op, logic [63:0] nm, logic [63:0] ph,
			logic [7:0] pos);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		name_key <= nm;
		phone_key <= ph;
		position <= pos;
		do @(posedge clk); while (in_stall);
		table_model.note_request(op, nm, ph, pos);
		words_sent++;
	endtask

	function automatic logic [63:0] pick_name();
		case ($urandom_range(0, 3))
			0: return table_model.count > 0 ?
					table_model.names[$urandom_range(0, table_model.count - 1)] :
					name_pool[$urandom_range(0, 15)];
			1: return name_pool[$urandom_range(0, 15)];
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [63:0] pick_phone();
		case ($urandom_range(0, 3))
			0: return table_model.count > 0 ?
					table_model.phones[$urandom_range(0, table_model.count - 1)] :
					phone_pool[$urandom_range(0, 15)];
			1: return phone_pool[$urandom_range(0, 15)];
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [7:0] pick_position();
		if ($urandom_range(0, 7) == 0)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(0, table_model.count + 1));
	endfunction

	initial begin
		int pick;
		logic [3:0] op;
		for (int i = 0; i < 16; i++) begin
			name_pool[i] = {$urandom, $urandom};
			phone_pool[i] = {$urandom, $urandom};
		end
		name_pool[0] = '0;
		name_pool[1] = '1;
		phone_pool[0] = '0;
		phone_pool[1] = '1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, unused codes, edge keys, refusals and hits
		send_request(OP_RM_NAME, '0, '0, '0);
		send_request(OP_RM_PHONE, '0, '0, '0);
		send_request(OP_RM_POS, '0, '0, '0);
		send_request(OP_SEQ_FIND, '0, '0, '0);
		send_request(OP_BIN_FIND, '1, '0, '0);
		send_request(OP_SORT, '0, '0, '0);
		send_request(OpUnusedLo, '1, '1, '1);
		send_request(OpUnusedHi, '0, '0, '0);
		send_request(OP_INS_HEAD, '1, '0, '0);
		send_request(OP_SORT, '0, '0, '0);
		send_request(OP_INS_END, '0, '1, '0);
		send_request(OP_INS_AT, 64'h4d41525941000000, 64'h5555, 8'd1);
		send_request(OP_INS_AT, 64'h1234, 64'h6666, 8'd5);
		send_request(OP_INS_AT, 64'h1235, 64'h6667, '1);
		send_request(OP_INS_HEAD, '1, 64'h7777, '0);
		send_request(OP_INS_END, 64'h9999, 64'h5555, '0);
		send_request(OP_SORT, '0, '0, '0);
		send_request(OP_SEQ_FIND, 64'h4d41525941000000, '0, '0);
		send_request(OP_BIN_FIND, '1, '0, '0);
		send_request(OP_BIN_FIND, 64'h4d41525941000001, '0, '0);
		send_request(OP_SEQ_FIND, 64'h42, '0, '0);
		send_request(OP_RM_NAME, 64'h42, '0, '0);
		send_request(OP_RM_PHONE, '0, '1, '0);
		send_request(OP_RM_POS, '0, '0, 8'd200);
		send_request(OP_RM_POS, '0, '0, '0);

		// fill to capacity, probe the full table, then drain most of it
		while (table_model.count < Capacity)
			send_request(OP_INS_END, {$urandom, $urandom}, {$urandom, $urandom}, '0);
		send_request(OP_INS_HEAD, {$urandom, $urandom}, {$urandom, $urandom}, '0);
		send_request(OP_INS_AT, {$urandom, $urandom}, {$urandom, $urandom}, 8'd128);
		send_request(OP_BIN_FIND, table_model.names[77], '0, '0);
		send_request(OP_RM_POS, '0, '0, 8'd127);
		send_request(OP_INS_AT, 64'h77, 64'h88, 8'd127);
		send_request(OP_RM_POS, '0, '0, 8'd128);
		while (table_model.count > 4)
			send_request(OP_RM_POS, '0, '0, 8'($urandom_range(0, table_model.count - 1)));

		// random mix with the table kept small
		for (int n = 0; n < RandomItems; n++) begin
			if (n == RandomItems - QuietTail)
				quiet = 1;
			pick = $urandom_range(0, 99);
			if (pick < 38 && table_model.count >= SmallTable)
				pick = 50;
			if (pick < 38)
				op = 4'($urandom_range(OP_INS_HEAD, OP_INS_END));
			else if (pick < 62)
				op = 4'($urandom_range(OP_RM_NAME, OP_RM_POS));
			else if (pick < 69)
				op = OP_SORT;
			else if (pick < 82)
				op = OP_SEQ_FIND;
			else if (pick < 96)
				op = OP_BIN_FIND;
			else
				op = 4'($urandom_range(OpUnusedLo, OpUnusedHi));
			send_request(op, pick_name(), pick_phone(), pick_position());
		end
		in_valid <= 1'b0;

		while (table_model.owed.size() > 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		$display("Covered %0d request words, %0d replies checked, including a full table.",
				words_sent, table_model.checked);
		if (table_model.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
`default_nettype wire

[files.f]
design/sktab_pkg.sv
design/sktab_ram.sv
design/sorted_key_table_engine_top.sv
design/sktab_checker.sv
sim/sorted_key_table_engine_top_tb.sv
